/* hw/rtl/rlt_pkg.sv */
package rlt_pkg;

	// Operation codes on the request channel.
	localparam logic [1:0] OP_WRITE_LOCK = 2'd0;
	localparam logic [1:0] OP_READ_LOCK  = 2'd1;
	localparam logic [1:0] OP_UNLOCK     = 2'd2;

	// Response status codes.
	localparam logic [1:0] ST_GRANTED  = 2'd0;
	localparam logic [1:0] ST_RETRY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	// Slot occupancy codes.
	localparam logic [1:0] KIND_FREE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_HOLD = 3'b100
	} rlt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic evaluate;
	} rlt_cmd_t;

endpackage

/* hw/rtl/rlt_ctrl.sv */
module rlt_ctrl
	import rlt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rlt_cmd_t cmd
);

	rlt_state_t state_q;
	rlt_state_t state_d;

	// A new request may be taken when idle, or when the held response leaves this cycle.
	assign in_ready  = (state_q == S_IDLE) || ((state_q == S_HOLD) && out_ready);
	assign out_valid = (state_q == S_HOLD);

	assign cmd.capture  = in_valid && in_ready;
	assign cmd.evaluate = (state_q == S_EVAL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_HOLD;
			end
			S_HOLD: begin
				if (out_ready) state_d = in_valid ? S_EVAL : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_eval_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |=> (state_q == S_HOLD))
		else $error("evaluation did not produce a response");

	a_capture_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.evaluate)
		else $error("captured request was not evaluated");

	a_hold_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && !cmd.evaluate))
		else $error("response dropped while stalled");

endmodule

/* hw/rtl/rlt_datapath.sv */
module rlt_datapath
	import rlt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rlt_cmd_t    cmd,
	input  logic [1:0]  operation,
	input  logic [63:0] range_start,
	input  logic [63:0] range_end,
	input  logic [3:0]  slot_to_free,
	output logic [1:0]  status,
	output logic [3:0]  ticket
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	logic [1:0]  op_q;
	logic [63:0] first_q;
	logic [63:0] last_q;
	logic [3:0]  slot_q;

	logic [1:0]  kind_q  [TABLE_ENTRIES];
	logic [63:0] lo_q    [TABLE_ENTRIES];
	logic [63:0] hi_q    [TABLE_ENTRIES];

	logic [1:0]  status_q;
	logic [3:0]  ticket_q;

	logic [TABLE_ENTRIES-1:0] clash;
	logic [TABLE_ENTRIES-1:0] free;
	logic                     any_clash;
	logic                     any_free;
	logic [IDX_W-1:0]         pick;
	logic                     is_lock;
	logic                     is_write;
	logic                     grant;

	assign is_lock  = (op_q == OP_WRITE_LOCK) || (op_q == OP_READ_LOCK);
	assign is_write = (op_q == OP_WRITE_LOCK);

	// Per-slot overlap test against the captured request.
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			free[i]  = (kind_q[i] == KIND_FREE);
			clash[i] = (is_write ? (kind_q[i] != KIND_FREE) : (kind_q[i] == KIND_WRITE))
				&& (lo_q[i] <= last_q) && (first_q <= hi_q[i]);
		end
	end

	assign any_clash = |clash;
	assign any_free  = |free;
	assign grant     = is_lock && !any_clash && any_free;

	// Lowest free slot wins.
	always_comb begin
		pick = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (free[i]) pick = IDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			first_q <= range_start;
			last_q  <= range_end;
			slot_q  <= slot_to_free;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			if (op_q == OP_UNLOCK) begin
				status_q <= ST_RELEASED;
			end else if (!is_lock || any_clash) begin
				status_q <= ST_RETRY;
			end else if (!any_free) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_GRANTED;
			end
			ticket_q <= grant ? 4'(pick) : 4'd0;
		end
	end

	// Range bounds are written only on a grant; their reset value is never observed.
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (cmd.evaluate && grant && (pick == IDX_W'(i))) begin
				lo_q[i] <= first_q;
				hi_q[i] <= last_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) kind_q[i] <= KIND_FREE;
		end else if (cmd.evaluate) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (grant && (pick == IDX_W'(i))) begin
					kind_q[i] <= is_write ? KIND_WRITE : KIND_READ;
				end else if ((op_q == OP_UNLOCK) && (32'(slot_q) == i)) begin
					kind_q[i] <= KIND_FREE;
				end
			end
		end
	end

	assign status = status_q;
	assign ticket = ticket_q;

	a_ticket_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evaluate |=> ((status_q == ST_GRANTED) || (ticket_q == 4'd0)))
		else $error("nonzero ticket on a response that is not a grant");

endmodule

/* hw/rtl/range_lock_table_core.sv */
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_ready  operation, range_start, range_end, slot_to_free
// response  out        out_valid/out_ready  status, ticket
//
// Each request is first captured from the transfer, then compared against every
// slot in parallel while the table is updated. The response register holds the
// result; a new request is taken in the cycle that response is taken, so under
// back-to-back traffic each request waits until the previous response leaves.
// Reset frees every slot at once; no clearing pass is needed.
// A stalled response holds the table and blocks new requests until it is taken.
module range_lock_table_core
	import rlt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] range_start,
	input  logic [63:0] range_end,
	input  logic [3:0]  slot_to_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  ticket
);

	rlt_cmd_t cmd;

	// The controller sequences capture, evaluation and response hold.
	rlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath owns the slot table, the comparators and the response register.
	rlt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.range_start  (range_start),
		.range_end    (range_end),
		.slot_to_free (slot_to_free),
		.status       (status),
		.ticket       (ticket)
	);

endmodule
